@@ hdl/rtc_calendar_with_set_keys_top_macros.svh @@
// Assertion macros for the real-time clock calendar block.
// Both macros expect i_clk and i_rst_n to exist in the module that uses them.
`ifndef RTC_CALENDAR_WITH_SET_KEYS_TOP_MACROS_SVH
`define RTC_CALENDAR_WITH_SET_KEYS_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RTCC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RTCC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/rtcc_pkg.sv @@
// Shared types, codes and helpers for the real-time clock calendar.
// Used by rtcc_step and rtc_calendar_with_set_keys_top; depends on nothing.
package rtcc_pkg;

    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_KEY  = 2'd1;
    localparam logic [1:0] REQ_MODE = 2'd2;

    localparam logic [1:0] KEY_LOW  = 2'd0;
    localparam logic [1:0] KEY_MID  = 2'd1;
    localparam logic [1:0] KEY_HIGH = 2'd2;

    localparam logic [5:0] SEC_MAX       = 6'd59;
    localparam logic [5:0] MIN_MAX       = 6'd59;
    localparam logic [4:0] HOUR_MAX      = 5'd23;
    localparam logic [4:0] DAY_FIRST     = 5'd1;
    localparam logic [3:0] MONTH_FIRST   = 4'd1;
    localparam logic [3:0] MONTH_MAX     = 4'd12;
    localparam logic [6:0] YEAR_MAX      = 7'd99;
    localparam logic [7:0] CENTURY_LIMIT = 8'd100;
    localparam logic [6:0] CENTURY_BASE  = 7'd20;
    localparam logic [7:0] TPS_RESET     = 8'd20;

    typedef struct packed {
        logic [5:0] secs;
        logic [5:0] mins;
        logic [4:0] hrs;
        logic [4:0] day;
        logic [3:0] month;
        logic [6:0] year;
        logic [6:0] century;
        logic       mode;
    } t_cal;

    localparam t_cal CAL_RESET = '{
        secs: 6'd0, mins: 6'd0, hrs: 5'd0, day: DAY_FIRST, month: MONTH_FIRST,
        year: 7'd0, century: CENTURY_BASE, mode: 1'b0
    };

    // Since 100 is a multiple of four, the full-year rule reduces to the two
    // digit fields: a year ending in 00 is leap only when the century is.
    function automatic logic is_leap(input logic [6:0] year, input logic [6:0] century);
        logic leap;
        leap = (year[1:0] == 2'd0) && ((year != 7'd0) || (century[1:0] == 2'd0));
        return leap;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        if (month inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
            len = 5'd30;
        end else if (month == 4'd2) begin
            len = leap ? 5'd29 : 5'd28;
        end else begin
            len = 5'd31;
        end
        return len;
    endfunction

endpackage

@@ hdl/rtcc_step.sv @@
// Next-state logic of the clock calendar for one input word.
// Depends on rtcc_pkg for the state struct, codes and month lengths.
module rtcc_step (
    input  rtcc_pkg::t_cal i_cal,
    input  logic [7:0]     i_tick_count,
    input  logic [7:0]     i_tps,
    input  logic [1:0]     i_req,
    input  logic [1:0]     i_sel,
    output rtcc_pkg::t_cal o_cal,
    output logic [7:0]     o_tick_count
);
    import rtcc_pkg::*;

    logic [4:0] mlen;
    logic [8:0] cnt_inc;
    logic [7:0] cent_inc;
    logic [6:0] year_next;
    logic [6:0] cent_next;

    always_comb begin
        mlen     = month_len(i_cal.month, is_leap(i_cal.year, i_cal.century));
        cnt_inc  = {1'b0, i_tick_count} + 9'd1;
        cent_inc = {1'b0, i_cal.century} + 8'd1;

        if (i_cal.year < YEAR_MAX) begin
            year_next = i_cal.year + 7'd1;
            cent_next = i_cal.century;
        end else begin
            year_next = 7'd0;
            cent_next = (cent_inc >= CENTURY_LIMIT) ? CENTURY_BASE : cent_inc[6:0];
        end

        o_cal        = i_cal;
        o_tick_count = i_tick_count;

        case (i_req)
            REQ_TICK: begin
                if (cnt_inc >= {1'b0, i_tps}) begin
                    o_tick_count = 8'd0;
                    if (i_cal.secs < SEC_MAX) begin
                        o_cal.secs = i_cal.secs + 6'd1;
                    end else begin
                        o_cal.secs = 6'd0;
                        if (i_cal.mins < MIN_MAX) begin
                            o_cal.mins = i_cal.mins + 6'd1;
                        end else begin
                            o_cal.mins = 6'd0;
                            if (i_cal.hrs < HOUR_MAX) begin
                                o_cal.hrs = i_cal.hrs + 5'd1;
                            end else begin
                                o_cal.hrs = 5'd0;
                                if (i_cal.day < mlen) begin
                                    o_cal.day = i_cal.day + 5'd1;
                                end else begin
                                    o_cal.day = DAY_FIRST;
                                    if (i_cal.month < MONTH_MAX) begin
                                        o_cal.month = i_cal.month + 4'd1;
                                    end else begin
                                        o_cal.month   = MONTH_FIRST;
                                        o_cal.year    = year_next;
                                        o_cal.century = cent_next;
                                    end
                                end
                            end
                        end
                    end
                end else begin
                    o_tick_count = cnt_inc[7:0];
                end
            end
            REQ_KEY: begin
                if (!i_cal.mode) begin
                    case (i_sel)
                        KEY_LOW: begin
                            o_cal.secs = (i_cal.secs >= SEC_MAX) ? 6'd0 : i_cal.secs + 6'd1;
                        end
                        KEY_MID: begin
                            o_cal.mins = (i_cal.mins >= MIN_MAX) ? 6'd0 : i_cal.mins + 6'd1;
                        end
                        KEY_HIGH: begin
                            o_cal.hrs = (i_cal.hrs >= HOUR_MAX) ? 5'd0 : i_cal.hrs + 5'd1;
                        end
                        default: begin
                        end
                    endcase
                end else begin
                    case (i_sel)
                        KEY_LOW: begin
                            o_cal.day = (i_cal.day >= mlen) ? DAY_FIRST : i_cal.day + 5'd1;
                        end
                        KEY_MID: begin
                            o_cal.month = (i_cal.month >= MONTH_MAX) ? MONTH_FIRST
                                                                     : i_cal.month + 4'd1;
                        end
                        KEY_HIGH: begin
                            o_cal.year    = year_next;
                            o_cal.century = cent_next;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            REQ_MODE: begin
                o_cal.mode = ~i_cal.mode;
            end
            default: begin
            end
        endcase
    end

endmodule

@@ hdl/rtc_calendar_with_set_keys_top.sv @@
// Top level of the real-time clock calendar with set keys.
// Depends on rtcc_pkg, rtcc_step and rtc_calendar_with_set_keys_top_macros.svh.
//
//   channel  handshake                  payload
//   in       i_in_valid / o_in_stall    i_req_type, i_key_sel
//   out      o_out_valid / i_out_stall  o_secs .. o_century_val, o_date_mode
//   cfg      i_cfg_valid / o_cfg_ready  i_cfg_data (ticks per second)
//
// A word accepted into the input register goes through the calendar update and lands in the
// result register once the result side is not stalled.
// While o_in_stall is low a new word is accepted every cycle; state carries word to word.
// A stall on the result side holds the result register and, one word later, the input.
// Synchronous active-low reset restores the clock to 00:00:00, day 1, month 1, year 2000.
module rtc_calendar_with_set_keys_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_req_type,
    input  logic [1:0] i_key_sel,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [5:0] o_secs,
    output logic [5:0] o_mins,
    output logic [4:0] o_hrs,
    output logic [4:0] o_day_of_month,
    output logic [3:0] o_month_num,
    output logic [6:0] o_year_low,
    output logic [6:0] o_century_val,
    output logic       o_date_mode,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);
    import rtcc_pkg::*;

    `include "rtc_calendar_with_set_keys_top_macros.svh"

    logic        r_in_valid;
    logic [1:0]  r_in_req;
    logic [1:0]  r_in_sel;
    logic        r_out_valid;
    t_cal        r_out;
    t_cal        r_cal;
    logic [7:0]  r_tick_count;
    logic [7:0]  r_tps;
    t_cal        n_cal;
    logic [7:0]  n_tick_count;
    logic        w_adv;
    logic        w_fire;
    logic        w_time_ok;
    logic        w_date_ok;
    logic        w_out_ok;
    logic        w_mode_fire;
    logic [48:0] w_state;

    assign w_adv       = !r_out_valid || !i_out_stall;
    assign w_fire      = r_in_valid && w_adv;
    assign o_in_stall  = r_in_valid && !w_adv;
    assign o_cfg_ready = 1'b1;

    rtcc_step u_step (
        .i_cal        (r_cal),
        .i_tick_count (r_tick_count),
        .i_tps        (r_tps),
        .i_req        (r_in_req),
        .i_sel        (r_in_sel),
        .o_cal        (n_cal),
        .o_tick_count (n_tick_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_cal        <= CAL_RESET;
            r_tick_count <= 8'd0;
            r_tps        <= TPS_RESET;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
            if (w_fire) begin
                r_cal        <= n_cal;
                r_tick_count <= n_tick_count;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_tps <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_req <= i_req_type;
            r_in_sel <= i_key_sel;
        end
        if (w_fire) begin
            r_out <= n_cal;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_secs         = r_out.secs;
    assign o_mins         = r_out.mins;
    assign o_hrs          = r_out.hrs;
    assign o_day_of_month = r_out.day;
    assign o_month_num    = r_out.month;
    assign o_year_low     = r_out.year;
    assign o_century_val  = r_out.century;
    assign o_date_mode    = r_out.mode;

    assign w_time_ok   = (r_cal.secs <= SEC_MAX) && (r_cal.mins <= MIN_MAX)
                         && (r_cal.hrs <= HOUR_MAX);
    assign w_date_ok   = (r_cal.day >= DAY_FIRST) && (r_cal.month >= MONTH_FIRST)
                         && (r_cal.month <= MONTH_MAX) && (r_cal.year <= YEAR_MAX)
                         && (r_cal.century >= CENTURY_BASE)
                         && ({1'b0, r_cal.century} < CENTURY_LIMIT);
    assign w_out_ok    = r_out_valid && (r_out == r_cal);
    assign w_mode_fire = w_fire && (r_in_req == REQ_MODE);
    assign w_state     = {r_cal, r_tick_count};

    `RTCC_ASSERT_NOW(a_time_range, 1'b1, w_time_ok, "time field out of range")
    `RTCC_ASSERT_NOW(a_date_range, 1'b1, w_date_ok, "date field out of range")
    `RTCC_ASSERT_NEXT(a_result_is_state, w_fire, w_out_ok, "result does not match state")
    `RTCC_ASSERT_NEXT(a_mode_toggles, w_mode_fire, r_cal.mode != $past(r_cal.mode), "mode lost")
    `RTCC_ASSERT_NEXT(a_hold_when_idle, !w_fire, w_state == $past(w_state), "state moved idle")

endmodule
